### hdl/tasag_pkg.sv
`default_nettype none

package tasag_pkg;

	// Register map, in word order on the configuration port.
	typedef enum logic [2:0] {
		REG_RANK,
		REG_DIM0,
		REG_DIM1,
		REG_DIM2,
		REG_DIM3,
		REG_FIRST_AXIS,
		REG_SECOND_AXIS,
		REG_ELEMENT_BYTES
	} reg_index_t;

	localparam int ADDR_W      = 5;
	localparam int DATA_W      = 32;
	localparam int VALUE_W     = 64;
	localparam int INDEX_W     = 32;
	localparam int OFFSET_W    = 35;
	localparam int OUT_PAD_W   = 5;
	localparam int OUT_TDATA_W = VALUE_W + OFFSET_W + OUT_PAD_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// Element counts above this value are flagged as an error.
	localparam logic [32:0] TOTAL_LIMIT = 33'h1_0000_0000;

	// Derived configuration status seen by the stream side.
	typedef struct packed {
		logic       busy;
		logic       restart;
		logic       err;
		logic       size_ok;
		logic [1:0] size_shift;
	} cfg_status_t;

	// One element after address generation, as held in the queue.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [INDEX_W-1:0] dest_index;
		logic               last;
		logic               err;
	} item_t;

endpackage

`default_nettype wire

### hdl/tensor_axis_swap_address_generator.sv
// Channel   Direction  Handshake               Payload
// s_*       in         s_tvalid / s_tready     source element, row-major source order
// m_*       out        m_tvalid / m_tready     element, destination byte offset, last, error
// APB       in         psel, penable, pwrite   eight configuration registers, word spaced
//
// One element is taken per cycle and one result is produced per cycle when
// no setup sweep, full queue or m_* stall holds the flow; the result of an
// s_* transfer passes through the queue and then the output register to m_*.
// After reset and after every register write a setup sweep computes the
// strides, in init, stride and delta steps; s_tready is low during it.
// A four-entry queue separates the address counter from the output
// register, so a stall on m_* reaches s_tready only once the queue fills.
`default_nettype none

module tensor_axis_swap_address_generator import tasag_pkg::*; #(
	parameter int MAX_RANK  = 4,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Source elements.
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// [63:0] element_value
	input  wire logic [VALUE_W-1:0]     s_tdata,
	// Results.
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// [63:0] element_out, [98:64] dest_byte_offset, [103:99] zero
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tlast,
	// [0] axis_error
	output logic                        m_tuser,
	// Configuration.
	input  wire logic                   psel,
	input  wire logic                   penable,
	input  wire logic                   pwrite,
	input  wire logic [ADDR_W-1:0]      paddr,
	input  wire logic [DATA_W-1:0]      pwdata,
	output logic      [DATA_W-1:0]      prdata,
	output logic                        pready
);

	// Extents and per-axis index steps are held stable by the setup logic
	// for as long as elements are being streamed.
	logic [SIZE_BITS-1:0] ext [MAX_RANK];
	logic [INDEX_W-1:0]   step_delta [MAX_RANK];
	cfg_status_t          status;

	logic  q_full;
	logic  q_push;
	item_t q_push_item;
	logic  q_pop;
	item_t q_pop_item;
	logic  q_not_empty;

	// Register file plus the stride sweep that runs after each write.
	tasag_cfg #(
		.MAX_RANK  (MAX_RANK),
		.SIZE_BITS (SIZE_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.ext        (ext),
		.step_delta (step_delta),
		.status     (status)
	);

	// Front: source position counter and running destination index.
	tasag_front #(
		.MAX_RANK  (MAX_RANK),
		.SIZE_BITS (SIZE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.ext        (ext),
		.step_delta (step_delta),
		.status     (status),
		.q_full     (q_full),
		.push       (q_push),
		.push_item  (q_push_item)
	);

	// Queue between the counter and the output stage.
	tasag_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.not_empty (q_not_empty)
	);

	// Back: byte offset scaling and the registered output transfer.
	tasag_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (q_not_empty),
		.pop_item  (q_pop_item),
		.pop       (q_pop),
		.status    (status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

endmodule

`default_nettype wire

### hdl/tasag_cfg.sv
`default_nettype none

module tasag_cfg import tasag_pkg::*; #(
	parameter int MAX_RANK  = 4,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]    prdata,
	output logic                      pready,
	output logic      [SIZE_BITS-1:0] ext [MAX_RANK],
	output logic      [INDEX_W-1:0]   step_delta [MAX_RANK],
	output cfg_status_t               status
);

	localparam int RW  = $clog2(MAX_RANK);
	localparam int LRW = $clog2(MAX_RANK + 1);
	localparam int TPW = 33 + SIZE_BITS;
	localparam int RPW = INDEX_W + SIZE_BITS;

	typedef enum logic [1:0] {S_INIT, S_STRIDE, S_DELTA, S_IDLE} sweep_state_t;

	logic [2:0]  rank_q;
	logic [15:0] dim_q [4];
	logic [2:0]  first_q;
	logic [2:0]  second_q;
	logic [3:0]  ebytes_q;

	logic [ADDR_W-3:0] reg_idx;
	logic              wr;

	logic              rank_over;
	logic [LRW-1:0]    live_rank;
	logic [MAX_RANK-1:0] zero_ext;

	logic signed [4:0] p_c, q_c;
	logic              p_ok, q_ok, swap_en, axis_err;

	sweep_state_t      state_q;
	logic [RW-1:0]     k_q;
	logic [RW-1:0]     perm_k;
	logic              k_in_rank;
	logic [INDEX_W-1:0] run_q;
	logic [32:0]       total_q;
	logic              over_q;
	logic [INDEX_W-1:0] acc_q;
	logic [INDEX_W-1:0] stride_q [MAX_RANK];
	logic [INDEX_W-1:0] step_delta_q [MAX_RANK];

	logic [TPW-1:0]    total_prod;
	logic [RPW-1:0]    run_prod;
	logic [RPW-1:0]    wrap_prod;

	function automatic logic signed [4:0] canon(input logic [2:0] raw, input logic [2:0] r);
		logic signed [4:0] v;
		v = {{2{raw[2]}}, raw};
		if (raw[2]) begin
			v = v + $signed({2'b00, r});
		end
		return v;
	endfunction

	assign reg_idx = paddr[ADDR_W-1:2];
	assign wr      = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q   <= 3'd2;
			dim_q[0] <= 16'd1;
			dim_q[1] <= 16'd1;
			dim_q[2] <= 16'd1;
			dim_q[3] <= 16'd1;
			first_q  <= 3'd0;
			second_q <= 3'd1;
			ebytes_q <= 4'd4;
		end else if (wr) begin
			case (reg_index_t'(reg_idx))
				REG_RANK:          rank_q   <= pwdata[2:0];
				REG_DIM0:          dim_q[0] <= pwdata[15:0];
				REG_DIM1:          dim_q[1] <= pwdata[15:0];
				REG_DIM2:          dim_q[2] <= pwdata[15:0];
				REG_DIM3:          dim_q[3] <= pwdata[15:0];
				REG_FIRST_AXIS:    first_q  <= pwdata[2:0];
				REG_SECOND_AXIS:   second_q <= pwdata[2:0];
				REG_ELEMENT_BYTES: ebytes_q <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_index_t'(reg_idx))
			REG_RANK:          prdata = DATA_W'(rank_q);
			REG_DIM0:          prdata = DATA_W'(dim_q[0]);
			REG_DIM1:          prdata = DATA_W'(dim_q[1]);
			REG_DIM2:          prdata = DATA_W'(dim_q[2]);
			REG_DIM3:          prdata = DATA_W'(dim_q[3]);
			REG_FIRST_AXIS:    prdata = DATA_W'(first_q);
			REG_SECOND_AXIS:   prdata = DATA_W'(second_q);
			REG_ELEMENT_BYTES: prdata = DATA_W'(ebytes_q);
			default:           prdata = '0;
		endcase
	end

	// Extents in use: zero is counted as one, axes past the rank are one.
	assign rank_over = int'(rank_q) > MAX_RANK;
	assign live_rank = rank_over ? LRW'(MAX_RANK) : LRW'(rank_q);

	for (genvar i = 0; i < MAX_RANK; i++) begin : g_ext
		if (i < 4) begin : g_reg
			logic [SIZE_BITS-1:0] raw;
			logic                 in_rank;
			assign raw         = SIZE_BITS'(dim_q[i]);
			assign in_rank     = LRW'(i) < live_rank;
			assign zero_ext[i] = in_rank && (raw == '0);
			assign ext[i]      = (in_rank && (raw != '0)) ? raw : SIZE_BITS'(1);
		end else begin : g_fixed
			assign zero_ext[i] = 1'b0;
			assign ext[i]      = SIZE_BITS'(1);
		end
	end

	// Axis numbers after wrapping negative values by the rank.
	assign p_c      = canon(first_q, rank_q);
	assign q_c      = canon(second_q, rank_q);
	assign p_ok     = !p_c[4] && (p_c[3:0] < {1'b0, rank_q});
	assign q_ok     = !q_c[4] && (q_c[3:0] < {1'b0, rank_q});
	assign axis_err = (rank_q != 3'd0) && !(p_ok && q_ok);
	assign swap_en  = (rank_q != 3'd0) && p_ok && q_ok && !rank_over;

	always_comb begin
		perm_k = k_q;
		if (swap_en && (4'(k_q) == p_c[3:0])) begin
			perm_k = RW'(q_c[3:0]);
		end else if (swap_en && (4'(k_q) == q_c[3:0])) begin
			perm_k = RW'(p_c[3:0]);
		end
	end

	assign k_in_rank  = LRW'(k_q) < live_rank;
	assign total_prod = TPW'(total_q) * TPW'(ext[k_q]);
	assign run_prod   = RPW'(run_q) * RPW'(ext[perm_k]);
	assign wrap_prod  = RPW'(ext[k_q] - SIZE_BITS'(1)) * RPW'(stride_q[k_q]);

	// Setup sweep: destination strides innermost first, then the per-axis
	// index step that folds in the rewind of every inner axis.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			k_q     <= '0;
			run_q   <= '0;
			total_q <= '0;
			over_q  <= 1'b0;
			acc_q   <= '0;
			for (int i = 0; i < MAX_RANK; i++) begin
				stride_q[i]     <= '0;
				step_delta_q[i] <= '0;
			end
		end else if (wr) begin
			state_q <= S_INIT;
		end else begin
			case (state_q)
				S_INIT: begin
					for (int i = 0; i < MAX_RANK; i++) begin
						stride_q[i] <= '0;
					end
					run_q   <= INDEX_W'(1);
					total_q <= 33'd1;
					over_q  <= 1'b0;
					acc_q   <= '0;
					k_q     <= RW'(MAX_RANK - 1);
					state_q <= S_STRIDE;
				end
				S_STRIDE: begin
					if (k_in_rank) begin
						stride_q[perm_k] <= run_q;
						run_q            <= run_prod[INDEX_W-1:0];
					end
					if (!over_q) begin
						if (total_prod > TPW'(TOTAL_LIMIT)) begin
							over_q <= 1'b1;
						end else begin
							total_q <= total_prod[32:0];
						end
					end
					if (k_q == '0) begin
						k_q     <= RW'(MAX_RANK - 1);
						state_q <= S_DELTA;
					end else begin
						k_q <= k_q - RW'(1);
					end
				end
				S_DELTA: begin
					step_delta_q[k_q] <= stride_q[k_q] - acc_q;
					acc_q             <= acc_q + wrap_prod[INDEX_W-1:0];
					if (k_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						k_q <= k_q - RW'(1);
					end
				end
				S_IDLE: ;
				default: state_q <= S_INIT;
			endcase
		end
	end

	assign step_delta = step_delta_q;

	always_comb begin
		status.busy    = state_q != S_IDLE;
		status.restart = state_q == S_INIT;
		status.err     = rank_over || (|zero_ext) || axis_err || over_q;
		case (ebytes_q)
			4'd1: begin status.size_ok = 1'b1; status.size_shift = 2'd0; end
			4'd2: begin status.size_ok = 1'b1; status.size_shift = 2'd1; end
			4'd4: begin status.size_ok = 1'b1; status.size_shift = 2'd2; end
			4'd8: begin status.size_ok = 1'b1; status.size_shift = 2'd3; end
			default: begin status.size_ok = 1'b0; status.size_shift = 2'd0; end
		endcase
	end

endmodule

`default_nettype wire

### hdl/tasag_front.sv
`default_nettype none

module tasag_front import tasag_pkg::*; #(
	parameter int MAX_RANK  = 4,
	parameter int SIZE_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [VALUE_W-1:0]   s_tdata,
	input  wire logic [SIZE_BITS-1:0] ext [MAX_RANK],
	input  wire logic [INDEX_W-1:0]   step_delta [MAX_RANK],
	input  wire cfg_status_t          status,
	input  wire logic                 q_full,
	output logic                      push,
	output item_t                     push_item
);

	logic [MAX_RANK-1:0][SIZE_BITS-1:0] pos_q;
	logic [MAX_RANK-1:0][SIZE_BITS-1:0] pos_n;
	logic [INDEX_W-1:0]                 dest_q;
	logic [INDEX_W-1:0]                 delta;
	logic [MAX_RANK-1:0]                at_max;
	logic                               last;
	logic                               found;
	logic                               accept;
	logic [VALUE_W-1:0]                 value_mask;

	assign s_tready = !status.busy && !q_full;
	assign accept   = s_tvalid && s_tready;

	// Mixed-radix step: the innermost axis that is not at its end advances,
	// every axis inside it rewinds to zero.
	always_comb begin
		found = 1'b0;
		delta = '0;
		for (int a = 0; a < MAX_RANK; a++) begin
			at_max[a] = pos_q[a] == (ext[a] - SIZE_BITS'(1));
		end
		pos_n = pos_q;
		for (int a = MAX_RANK - 1; a >= 0; a--) begin
			if (!found) begin
				if (at_max[a]) begin
					pos_n[a] = '0;
				end else begin
					pos_n[a] = pos_q[a] + SIZE_BITS'(1);
					delta    = step_delta[a];
					found    = 1'b1;
				end
			end
		end
		last = &at_max;
	end

	always_comb begin
		case (status.size_shift)
			2'd0:    value_mask = 64'h0000_0000_0000_00FF;
			2'd1:    value_mask = 64'h0000_0000_0000_FFFF;
			2'd2:    value_mask = 64'h0000_0000_FFFF_FFFF;
			default: value_mask = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		if (!status.size_ok) begin
			value_mask = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			dest_q <= '0;
		end else if (status.restart) begin
			pos_q  <= '0;
			dest_q <= '0;
		end else if (accept) begin
			if (last) begin
				pos_q  <= '0;
				dest_q <= '0;
			end else begin
				pos_q  <= pos_n;
				dest_q <= dest_q + delta;
			end
		end
	end

	assign push                 = accept;
	assign push_item.value      = s_tdata & value_mask;
	assign push_item.dest_index = dest_q;
	assign push_item.last       = last;
	assign push_item.err        = status.err;

	// The tensor wraps to its first element right after the last one.
	a_last_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last |=> (pos_q == '0) && (dest_q == '0))
		else $error("counter did not rewind after the last element");

	// A step that is not the last leaves some axis away from zero.
	a_step_advances: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !last |=> (|pos_q))
		else $error("counter did not advance");

	// The running index only moves on transfers or setup.
	a_index_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!accept && !status.restart |=> $stable(dest_q))
		else $error("destination index moved without a transfer");

endmodule

`default_nettype wire

### hdl/tasag_fifo.sv
`default_nettype none

module tasag_fifo import tasag_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	input  wire logic  pop,
	output item_t      pop_item,
	output logic       not_empty
);

	item_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full      = count_q == QCNT_W'(QUEUE_DEPTH);
	assign not_empty = count_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/tasag_back.sv
`default_nettype none

module tasag_back import tasag_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   not_empty,
	input  wire item_t                  pop_item,
	output logic                        pop,
	input  wire cfg_status_t            status,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,
	output logic                        m_tlast,
	output logic                        m_tuser
);

	logic                m_valid_q;
	logic [VALUE_W-1:0]  value_q;
	logic [OFFSET_W-1:0] offset_q;
	logic                last_q;
	logic                err_q;
	logic [OFFSET_W-1:0] offset;

	assign pop = not_empty && (!m_valid_q || m_tready);

	// Element sizes are powers of two, so the byte offset is a shift.
	always_comb begin
		offset = OFFSET_W'(pop_item.dest_index) << status.size_shift;
		if (pop_item.err || !status.size_ok) begin
			offset = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (pop) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			value_q  <= pop_item.value;
			offset_q <= offset;
			last_q   <= pop_item.last;
			err_q    <= pop_item.err;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {OUT_PAD_W'(0), offset_q, value_q};
	assign m_tlast  = last_q;
	assign m_tuser  = err_q;

endmodule

`default_nettype wire

### tb/tensor_axis_swap_address_generator_test.sv
`timescale 1ns / 100ps

module tensor_axis_swap_address_generator_test;
	import tasag_pkg::*;

	// Number of axis slots the block is built with.
	localparam int MAX_AXES = 4;
	// Cycles without any transfer or register access before the run is abandoned.
	localparam int QUIET_LIMIT = 1000;
	// Random source elements to send after the directed part.
	localparam int RANDOM_ELEMENTS = 1150;

	// One expected result transfer.
	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic                last;
		logic                err;
	} swap_result_t;

	// Mirrors the registers, the source counter and the destination index, and
	// holds the results that accepted source elements are still owed.
	class swap_offset_scoreboard;
		logic [2:0]  rank_q;
		logic [15:0] dim_q [MAX_AXES];
		logic [2:0]  first_q;
		logic [2:0]  second_q;
		logic [3:0]  ebytes_q;

		int          live_rank;
		logic [31:0] extent [MAX_AXES];
		logic [31:0] stride [MAX_AXES];
		logic        cfg_err;
		logic [3:0]  elem_size;
		logic [15:0] position [MAX_AXES];
		logic [31:0] dest_idx;

		swap_result_t expected_results [$];
		int           errors;
		int           inputs_seen;

		function new();
			rank_q   = 3'd2;
			for (int i = 0; i < MAX_AXES; i++)
				dim_q[i] = 16'd1;
			first_q  = 3'd0;
			second_q = 3'd1;
			ebytes_q = 4'd4;
			errors      = 0;
			inputs_seen = 0;
			recompute();
		endfunction

		// A negative axis counts back from the rank.
		function int axis_number(logic [2:0] raw, int r);
			int v;
			v = $signed(raw);
			if (v < 0)
				v += r;
			return v;
		endfunction

		// Derives extents, error flag and destination strides from the
		// registers, and restarts the counter at the first element.
		function void recompute();
			int              r;
			int              p;
			int              q;
			longint unsigned total;
			longint unsigned e;
			int              perm [MAX_AXES];
			logic [31:0]     ds [MAX_AXES];
			cfg_err = 1'b0;
			r = rank_q;
			live_rank = (r > MAX_AXES) ? MAX_AXES : r;
			if (r > MAX_AXES)
				cfg_err = 1'b1;
			total = 1;
			for (int i = 0; i < MAX_AXES; i++) begin
				e = dim_q[i];
				if (i < live_rank) begin
					if (e == 0) begin
						cfg_err = 1'b1;
						e = 1;
					end
					if (total <= 64'h1_0000_0000)
						total *= e;
				end else begin
					e = 1;
				end
				extent[i] = 32'(e);
				perm[i] = i;
				ds[i] = '0;
			end
			if (total > 64'h1_0000_0000)
				cfg_err = 1'b1;

			if (r > 0) begin
				p = axis_number(first_q, r);
				q = axis_number(second_q, r);
				if (p < 0 || p >= r || q < 0 || q >= r) begin
					cfg_err = 1'b1;
				end else if (r <= MAX_AXES) begin
					perm[p] = q;
					perm[q] = p;
				end
			end

			// Row-major strides of the destination shape, then mapped back onto
			// the source axes.
			if (live_rank > 0) begin
				ds[live_rank - 1] = 32'd1;
				for (int i = live_rank - 1; i > 0; i--)
					ds[i - 1] = ds[i] * extent[perm[i]];
			end
			for (int i = 0; i < MAX_AXES; i++)
				stride[i] = (i < live_rank) ? ds[perm[i]] : 32'd0;

			case (ebytes_q)
				4'd1, 4'd2, 4'd4, 4'd8: elem_size = ebytes_q;
				default: elem_size = 4'd0;
			endcase

			for (int i = 0; i < MAX_AXES; i++)
				position[i] = '0;
			dest_idx = '0;
		endfunction

		function void write_register(reg_index_t idx, logic [31:0] value);
			case (idx)
				REG_RANK:          rank_q   = value[2:0];
				REG_DIM0:          dim_q[0] = value[15:0];
				REG_DIM1:          dim_q[1] = value[15:0];
				REG_DIM2:          dim_q[2] = value[15:0];
				REG_DIM3:          dim_q[3] = value[15:0];
				REG_FIRST_AXIS:    first_q  = value[2:0];
				REG_SECOND_AXIS:   second_q = value[2:0];
				REG_ELEMENT_BYTES: ebytes_q = value[3:0];
				default: ;
			endcase
			recompute();
		endfunction

		// Works out the result owed for one accepted source element and steps
		// the mixed-radix counter.
		function void take_source_element(logic [VALUE_W-1:0] v);
			swap_result_t res;
			logic         last;
			inputs_seen++;
			case (elem_size)
				4'd0: v = '0;
				4'd1: v[63:8] = '0;
				4'd2: v[63:16] = '0;
				4'd4: v[63:32] = '0;
				default: ;
			endcase
			last = 1'b1;
			for (int i = 0; i < live_rank; i++)
				if (32'(position[i]) + 1 != extent[i])
					last = 1'b0;
			res.value  = v;
			res.offset = cfg_err ? '0 : OFFSET_W'(64'(dest_idx) * elem_size);
			res.last   = last;
			res.err    = cfg_err;
			expected_results.insert(expected_results.size(), res);

			if (last) begin
				for (int i = 0; i < MAX_AXES; i++)
					position[i] = '0;
				dest_idx = '0;
			end else begin
				for (int i = live_rank - 1; i >= 0; i--) begin
					if (32'(position[i]) + 1 < extent[i]) begin
						position[i] = position[i] + 1'b1;
						dest_idx += stride[i];
						break;
					end
					dest_idx -= (extent[i] - 1) * stride[i];
					position[i] = '0;
				end
			end
		endfunction

		function void check_field(string name, logic [63:0] want, logic [63:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
				errors++;
			end
		endfunction

		function void compare_result(logic [OUT_TDATA_W-1:0] data, logic tlast, logic tuser);
			swap_result_t want;
			if (expected_results.size() == 0) begin
				$error("result transfer with no element outstanding: data 0x%0h", data);
				errors++;
				return;
			end
			want = expected_results.pop_front();
			check_field("element_out", want.value, data[VALUE_W-1:0]);
			check_field("dest_byte_offset", 64'(want.offset),
				64'(data[VALUE_W+OFFSET_W-1:VALUE_W]));
			check_field("tdata padding", 64'd0, 64'(data[OUT_TDATA_W-1:VALUE_W+OFFSET_W]));
			check_field("last_element", 64'(want.last), 64'(tlast));
			check_field("axis_error", 64'(want.err), 64'(tuser));
		endfunction

		function int failures();
			if (expected_results.size() != 0)
				$error("%0d results never arrived", expected_results.size());
			return errors + expected_results.size();
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [VALUE_W-1:0]     s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   psel;
	logic                   penable;
	logic                   pwrite;
	logic [ADDR_W-1:0]      paddr;
	logic [DATA_W-1:0]      pwdata;
	logic [DATA_W-1:0]      prdata;
	logic                   pready;

	swap_offset_scoreboard sb;

	// Register values for the next setting, indexed by register.
	logic [31:0] next_setting [8];
	// When set, the source offers every element with no gap in front of it.
	bit          steady_source;
	// Raised by the main sequence to make the sink hold off for a long stretch.
	bit          sink_hold_request;
	int          quiet_cycles;

	tensor_axis_swap_address_generator u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int gap_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Element values lean on all-ones and zero now and then, to hit the
	// masking edges of every element size.
	function automatic logic [VALUE_W-1:0] random_element();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '1;
		if (r == 1)
			return '0;
		return {$urandom, $urandom};
	endfunction

	// Draws a full register setting. Most settings describe a well-formed
	// tensor of small extents so the last element comes around often; the rest
	// bring in rank zero, ranks above the slot count, zero or huge extents,
	// out-of-range axes and odd element sizes.
	task automatic draw_setting();
		int r;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 85)
			r = $urandom_range(1, MAX_AXES);
		else if (pick < 90)
			r = 0;
		else
			r = $urandom_range(5, 7);
		next_setting[REG_RANK] = r;
		for (int i = 0; i < MAX_AXES; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 76)
				next_setting[REG_DIM0 + i] = $urandom_range(1, 4);
			else if (pick < 88)
				next_setting[REG_DIM0 + i] = $urandom_range(5, 12);
			else if (pick < 94)
				next_setting[REG_DIM0 + i] = 0;
			else
				next_setting[REG_DIM0 + i] = $urandom_range(16'h0100, 16'hFFFF);
		end
		for (int i = 0; i < 2; i++) begin
			if (r >= 1 && r <= MAX_AXES && $urandom_range(0, 99) < 85)
				next_setting[REG_FIRST_AXIS + i] = ($urandom_range(0, 2 * r - 1) - r) & 7;
			else
				next_setting[REG_FIRST_AXIS + i] = $urandom_range(0, 7);
		end
		pick = $urandom_range(0, 99);
		if (pick < 85)
			next_setting[REG_ELEMENT_BYTES] = 1 << $urandom_range(0, 3);
		else
			next_setting[REG_ELEMENT_BYTES] = $urandom_range(0, 15);
	endtask

	task automatic directed_setting(input int r, input int d0, input int d1, input int d2,
			input int d3, input int first, input int second, input int eb);
		next_setting[REG_RANK]          = r;
		next_setting[REG_DIM0]          = d0;
		next_setting[REG_DIM1]          = d1;
		next_setting[REG_DIM2]          = d2;
		next_setting[REG_DIM3]          = d3;
		next_setting[REG_FIRST_AXIS]    = first & 7;
		next_setting[REG_SECOND_AXIS]   = second & 7;
		next_setting[REG_ELEMENT_BYTES] = eb;
	endtask

	// Waits until every accepted element has come back. Each element gives
	// exactly one result, so the block is idle once nothing is owed.
	task automatic wait_drained();
		while (sb.expected_results.size() != 0)
			@(posedge clk);
	endtask

	// Setup cycle, then access cycle; the register takes the value at the edge
	// that completes the access. The bus is left selected so that a following
	// write can start in the same cycle without a second assignment.
	task automatic apb_write(input reg_index_t idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.write_register(idx, value);
	endtask

	// Writes the selected registers of next_setting once the block is idle.
	task automatic program_registers(input logic [7:0] which);
		wait_drained();
		for (int i = 0; i < 8; i++)
			if (which[i])
				apb_write(reg_index_t'(i), next_setting[i]);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offers one element and returns in the cycle of its transfer. tvalid stays
	// high for a following element unless a gap is drawn.
	task automatic offer(input logic [VALUE_W-1:0] v);
		int gap;
		gap = steady_source ? 0 : gap_cycles();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= v;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.take_source_element(v);
	endtask

	task automatic end_burst();
		s_tvalid <= 1'b0;
	endtask

	task automatic send_elements(input int count);
		for (int i = 0; i < count; i++)
			offer(random_element());
		end_burst();
	endtask

	// Main sequence: reset, a directed pass over the special cases, then random
	// settings with random element bursts.
	initial begin
		int          random_sent;
		int          count;
		int          pick;
		logic [7:0]  which;
		bit          pressure_done;
		sb = new();
		steady_source     = 1'b0;
		sink_hold_request = 1'b0;
		pressure_done     = 1'b0;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setting: rank 2 with unit extents, so every element is the
		// last one, at offset zero, masked to four bytes.
		offer('1);
		offer('0);
		end_burst();

		// Plain 2x3 transpose of 8-byte elements, with the value extremes.
		directed_setting(2, 2, 3, 1, 1, 0, 1, 8);
		program_registers(8'hFF);
		offer('1);
		offer('0);
		offer(64'h5555_5555_5555_5555);
		offer(64'hAAAA_AAAA_AAAA_AAAA);
		offer(64'h8000_0000_0000_0001);
		offer(64'h0123_4567_89AB_CDEF);
		end_burst();

		// A scalar: rank zero never flags an error and every element is last.
		directed_setting(0, 3, 3, 3, 3, 0, 1, 1);
		program_registers(8'hFF);
		offer('1);
		offer(64'hFEDC_BA98_7654_3210);
		end_burst();

		// A rank above the slot count is an error but still counts.
		directed_setting(7, 2, 2, 2, 2, 0, 1, 2);
		program_registers(8'hFF);
		offer('1);
		offer(64'h1234_5678_9ABC_DEF0);
		end_burst();

		// An axis past the rank, beside a negative axis that folds back into range.
		directed_setting(2, 2, 2, 1, 1, 2, -1, 4);
		program_registers(8'hFF);
		offer('1);
		offer('1);
		end_burst();

		// A zero extent inside the rank is an error; it counts as one.
		directed_setting(3, 3, 0, 2, 1, 0, 2, 4);
		program_registers(8'hFF);
		offer('1);
		offer('0);
		end_burst();

		// More than 2^32 elements in total.
		directed_setting(3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 0, 2, 8);
		program_registers(8'hFF);
		offer('1);
		offer('1);
		end_burst();

		// An element size that is not a power of two zeroes value and offset.
		directed_setting(2, 2, 2, 1, 1, 1, 0, 3);
		program_registers(8'hFF);
		offer('1);
		offer('1);
		end_burst();

		// Full rank with negative axes for both the last and the first axis.
		directed_setting(4, 2, 1, 3, 2, -1, -4, 4);
		program_registers(8'hFF);
		offer('1);
		offer(64'h0000_0001_FFFF_FFFF);
		offer('1);
		end_burst();

		// Random part. A phase either carries on with the current tensor, or
		// rewrites some or all registers, which restarts the counter.
		random_sent = 0;
		while (random_sent < RANDOM_ELEMENTS) begin
			draw_setting();
			pick = $urandom_range(0, 99);
			if (pick < 15)
				which = 8'h00;
			else if (pick < 35)
				which = 8'hFF;
			else
				which = 8'($urandom_range(1, 255));
			program_registers(which);
			count = $urandom_range(4, 40);
			steady_source = ($urandom_range(0, 3) == 0);
			// Once, let the sink stop for a long while during a gapless burst so
			// the internal queue fills and the block pushes back on its input.
			// The burst starts only after the sink has begun its hold.
			if (!pressure_done && random_sent >= 400) begin
				pressure_done     = 1'b1;
				count             = 60;
				steady_source     = 1'b1;
				sink_hold_request = 1'b1;
				wait (!sink_hold_request);
			end
			send_elements(count);
			random_sent += count;
		end
		steady_source = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.failures() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Sink: ready is dropped for random stretches, and once for a long
	// stretch when the main sequence asks for it.
	initial begin
		int stall;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_hold_request) begin
				sink_hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (80) @(posedge clk);
			end else begin
				stall = gap_cycles();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				if ($urandom_range(0, 9) == 0)
					repeat ($urandom_range(30, 80)) @(posedge clk);
				else
					repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// Every result transfer is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.compare_result(m_tdata, m_tlast, m_tuser);
	end

	// Ends the run if nothing moves on either stream or the register port for
	// too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial quiet_cycles = 0;

endmodule
